// ===== src/adaptive_iq_balance_macros.svh =====
// ----------------------------------------------------------------------------
// iq balance assertion macros
// concurrent checks clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_IQ_BALANCE_MACROS_SVH
`define ADAPTIVE_IQ_BALANCE_MACROS_SVH

// consequent must hold in the same cycle
`define IQB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iq balance check failed");

// consequent must hold in the next cycle
`define IQB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iq balance check failed");

`endif

// ===== src/iqb_pkg.sv =====
// ----------------------------------------------------------------------------
// iqb_pkg
// shared types and constants of the adaptive iq balance block
// ----------------------------------------------------------------------------
package iqb_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 32;

    // fixed point positions
    localparam int GAIN_FRAC  = 14;
    localparam int PHASE_FRAC = 15;
    localparam int LEAK_SHIFT = 28;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE  = 2'd2;

    localparam logic signed [CFG_DATA_WIDTH-1:0] GAIN_RESET  = 16'sd16384;
    localparam logic signed [CFG_DATA_WIDTH-1:0] PHASE_RESET = 16'sd0;

    // sequencer steps, one multiply issued per multiplying step
    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_GAIN,
        STEP_PHASE,
        STEP_AIM,
        STEP_WRA,
        STEP_WIAI,
        STEP_WIAR,
        STEP_WRAI,
        STEP_TIM,
        STEP_RR,
        STEP_II,
        STEP_RI,
        STEP_UPD,
        STEP_FIN
    } iqb_step_t;

    typedef struct packed {
        iqb_step_t step;
        logic      accept;
        logic      finish;
    } iqb_ctrl_t;

endpackage

// ===== src/adaptive_iq_balance.sv =====
// ----------------------------------------------------------------------------
// adaptive_iq_balance
// static gain/phase fix followed by an adaptive image canceller with a
// leaky lms coefficient update, all products on one shared multiplier
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_ready    in_re, in_im, block_last
//  out       source     out_valid/out_ready  out_re, out_im, out_last
//  cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  enabled: after acceptance a beat walks the sequencer through nine products
//  issued to the shared multiplier plus the sum and update steps before the
//  next acceptance; the result is registered in the final step
//  bypass: an accepted beat goes straight to the final step
//  reset clears the coefficient, the sequencer and the output valid
//  a stalled output holds the sequencer in its final step until taken, while
//  one finished result waits in the output register
// ----------------------------------------------------------------------------
`include "adaptive_iq_balance_macros.svh"

module adaptive_iq_balance #(
    parameter int SAMPLE_WIDTH = iqb_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = iqb_pkg::COEF_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_re,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_im,
    input  logic                                 block_last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       out_re,
    output logic signed [SAMPLE_WIDTH-1:0]       out_im,
    output logic                                 out_last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [iqb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [iqb_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int S        = SAMPLE_WIDTH;
    localparam int C        = COEF_WIDTH;
    localparam int PW       = C + S;
    localparam int WW       = C + S + 2;
    localparam int MU_SHIFT = 2 * S - C + 15;
    localparam int MU_LSH   = (MU_SHIFT < 0) ? -MU_SHIFT : 0;
    localparam int MU_RSH   = (MU_SHIFT > 0) ? MU_SHIFT : 0;
    localparam int DW       = WW + 9 + MU_LSH;
    localparam int NW       = DW + 1;

    localparam logic signed [WW-1:0] S_MAX = {{(WW-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [WW-1:0] S_MIN = ~S_MAX;
    localparam logic signed [NW-1:0] C_MAX = {{(NW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [NW-1:0] C_MIN = ~C_MAX;

    function automatic logic signed [S-1:0] sat_s(input logic signed [WW-1:0] v);
        if (v > S_MAX)
            return S_MAX[S-1:0];
        if (v < S_MIN)
            return S_MIN[S-1:0];
        return v[S-1:0];
    endfunction

    function automatic logic signed [C-1:0] sat_c(input logic signed [NW-1:0] v);
        if (v > C_MAX)
            return C_MAX[C-1:0];
        if (v < C_MIN)
            return C_MIN[C-1:0];
        return v[C-1:0];
    endfunction

    // mu = 164 * 2^-MU_SHIFT (2^-15 at the default widths), 164 = 128 + 32 + 4
    function automatic logic signed [DW-1:0] mu_step(input logic signed [DW-1:0] x);
        logic signed [DW-1:0] m;
        m = (x <<< 7) + (x <<< 5) + (x <<< 2);
        return (m <<< MU_LSH) >>> MU_RSH;
    endfunction

    // configuration
    logic                                      enable_reg;
    logic signed [iqb_pkg::CFG_DATA_WIDTH-1:0] gain_reg;
    logic signed [iqb_pkg::CFG_DATA_WIDTH-1:0] phase_reg;

    // no write is taken while reset is held
    assign cfg_ready = rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            gain_reg   <= iqb_pkg::GAIN_RESET;
            phase_reg  <= iqb_pkg::PHASE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                iqb_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                iqb_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                iqb_pkg::REG_PHASE:  phase_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // sequencer
    iqb_pkg::iqb_ctrl_t ctrl;
    logic               out_valid_reg;
    logic               out_free;

    assign out_free = !out_valid_reg || out_ready;

    iqb_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .enable   (enable_reg),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // working registers
    logic signed [S-1:0]  re_reg;
    logic signed [S-1:0]  im_reg;
    logic                 last_reg;
    logic signed [S-1:0]  a_re_reg;
    logic signed [S-1:0]  a_im_reg;
    logic signed [S-1:0]  t_re_reg;
    logic signed [S-1:0]  t_im_reg;
    logic signed [PW:0]   acc_reg;
    logic signed [C-1:0]  coef_re_reg;
    logic signed [C-1:0]  coef_im_reg;

    // shared multiplier
    logic signed [C-1:0]  mul_a;
    logic signed [S-1:0]  mul_b;
    logic signed [PW-1:0] prod;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.step)
            iqb_pkg::STEP_GAIN:
            begin
                mul_a = C'(gain_reg);
                mul_b = re_reg;
            end
            iqb_pkg::STEP_PHASE:
            begin
                mul_a = C'(phase_reg);
                mul_b = re_reg;
            end
            iqb_pkg::STEP_WRA:
            begin
                mul_a = coef_re_reg;
                mul_b = a_re_reg;
            end
            iqb_pkg::STEP_WIAI:
            begin
                mul_a = coef_im_reg;
                mul_b = a_im_reg;
            end
            iqb_pkg::STEP_WIAR:
            begin
                mul_a = coef_im_reg;
                mul_b = a_re_reg;
            end
            iqb_pkg::STEP_WRAI:
            begin
                mul_a = coef_re_reg;
                mul_b = a_im_reg;
            end
            iqb_pkg::STEP_RR:
            begin
                mul_a = C'(t_re_reg);
                mul_b = t_re_reg;
            end
            iqb_pkg::STEP_II:
            begin
                mul_a = C'(t_im_reg);
                mul_b = t_im_reg;
            end
            iqb_pkg::STEP_RI:
            begin
                mul_a = C'(t_re_reg);
                mul_b = t_im_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    iqb_mul #(
        .AW (C),
        .BW (S)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // sums and saturation
    logic signed [WW-1:0] prod_w;
    logic signed [WW-1:0] acc_w;
    logic signed [S-1:0]  a_re_next;
    logic signed [S-1:0]  a_im_next;
    logic signed [S-1:0]  t_re_next;
    logic signed [S-1:0]  t_im_next;
    logic signed [DW-1:0] d_re;
    logic signed [DW-1:0] d_im;
    logic signed [NW-1:0] n_re;
    logic signed [NW-1:0] n_im;
    logic signed [C-1:0]  coef_re_next;
    logic signed [C-1:0]  coef_im_next;

    assign prod_w    = WW'(prod);
    assign acc_w     = WW'(acc_reg);
    assign a_re_next = sat_s(prod_w >>> iqb_pkg::GAIN_FRAC);
    assign a_im_next = sat_s(WW'(im_reg) + (prod_w >>> iqb_pkg::PHASE_FRAC));
    assign t_re_next = sat_s(WW'(a_re_reg) + (acc_w >>> (C - 1)));
    assign t_im_next = sat_s(WW'(a_im_reg) + ((acc_w - prod_w) >>> (C - 1)));

    // acc holds t_re^2 - t_im^2, prod holds t_re*t_im in the update step
    assign d_re = mu_step(DW'(acc_reg));
    assign d_im = mu_step(DW'(prod) <<< 1);
    assign n_re = NW'(coef_re_reg) - (NW'(coef_re_reg) >>> iqb_pkg::LEAK_SHIFT) - NW'(d_re);
    assign n_im = NW'(coef_im_reg) - (NW'(coef_im_reg) >>> iqb_pkg::LEAK_SHIFT) - NW'(d_im);

    always_comb
    begin
        coef_re_next = coef_re_reg;
        coef_im_next = coef_im_reg;
        if (ctrl.finish && last_reg)
        begin
            coef_re_next = '0;
            coef_im_next = '0;
        end
        else if (ctrl.step == iqb_pkg::STEP_UPD)
        begin
            coef_re_next = sat_c(n_re);
            coef_im_next = sat_c(n_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_re_reg <= '0;
            coef_im_reg <= '0;
        end
        else
        begin
            coef_re_reg <= coef_re_next;
            coef_im_reg <= coef_im_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            re_reg   <= in_re;
            im_reg   <= in_im;
            last_reg <= block_last;
            if (!enable_reg)
            begin
                t_re_reg <= in_re;
                t_im_reg <= in_im;
            end
        end
        case (ctrl.step)
            iqb_pkg::STEP_PHASE: a_re_reg <= a_re_next;
            iqb_pkg::STEP_AIM:   a_im_reg <= a_im_next;
            iqb_pkg::STEP_WIAI:  acc_reg  <= (PW+1)'(prod);
            iqb_pkg::STEP_WIAR:  acc_reg  <= acc_reg + (PW+1)'(prod);
            iqb_pkg::STEP_WRAI:
            begin
                t_re_reg <= t_re_next;
                acc_reg  <= (PW+1)'(prod);
            end
            iqb_pkg::STEP_TIM:   t_im_reg <= t_im_next;
            iqb_pkg::STEP_II:    acc_reg  <= (PW+1)'(prod);
            iqb_pkg::STEP_RI:    acc_reg  <= acc_reg - (PW+1)'(prod);
            default:             ;
        endcase
    end

    // output register
    logic                out_valid_next;
    logic signed [S-1:0] out_re_reg;
    logic signed [S-1:0] out_im_reg;
    logic                out_last_reg;

    assign out_valid_next = ctrl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_re_reg   <= t_re_reg;
            out_im_reg   <= t_im_reg;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign out_last  = out_last_reg;

    // checks
    `IQB_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready)
    `IQB_ASSERT_NEXT(coef_clear_at_block_end, ctrl.finish && last_reg,
                     coef_re_reg == '0 && coef_im_reg == '0)
    `IQB_ASSERT_NEXT(bypass_keeps_sample, ctrl.accept && !enable_reg,
                     t_re_reg == $past(in_re) && t_im_reg == $past(in_im))
    `IQB_ASSERT_NEXT(finish_loads_output, ctrl.finish, out_valid_reg)

endmodule

// ===== src/iqb_mul.sv =====
// ----------------------------------------------------------------------------
// iqb_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module iqb_mul #(
    parameter int AW = iqb_pkg::COEF_WIDTH_DEF,
    parameter int BW = iqb_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic signed [AW-1:0]     op_a,
    input  logic signed [BW-1:0]     op_b,
    output logic signed [AW+BW-1:0]  prod
);

    logic signed [AW+BW-1:0] prod_reg;
    logic signed [AW+BW-1:0] prod_next;

    assign prod_next = (AW+BW)'(op_a) * (AW+BW)'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== src/iqb_seq.sv =====
// ----------------------------------------------------------------------------
// iqb_seq
// step sequencer: walks the multiply schedule for one sample
// ----------------------------------------------------------------------------
module iqb_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              enable,
    input  logic              out_free,
    output logic              in_ready,
    output iqb_pkg::iqb_ctrl_t ctrl
);

    iqb_pkg::iqb_step_t state_reg;
    iqb_pkg::iqb_step_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iqb_pkg::STEP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctrl.step   = state_reg;
        ctrl.accept = 1'b0;
        ctrl.finish = 1'b0;
        unique case (state_reg)
            iqb_pkg::STEP_IDLE:
            begin
                // nothing is taken while reset is held
                in_ready    = rst_n;
                ctrl.accept = in_valid && rst_n;
                if (in_valid && rst_n)
                begin
                    // bypassed samples go straight to the output stage
                    state_next = enable ? iqb_pkg::STEP_GAIN : iqb_pkg::STEP_FIN;
                end
            end
            iqb_pkg::STEP_GAIN:  state_next = iqb_pkg::STEP_PHASE;
            iqb_pkg::STEP_PHASE: state_next = iqb_pkg::STEP_AIM;
            iqb_pkg::STEP_AIM:   state_next = iqb_pkg::STEP_WRA;
            iqb_pkg::STEP_WRA:   state_next = iqb_pkg::STEP_WIAI;
            iqb_pkg::STEP_WIAI:  state_next = iqb_pkg::STEP_WIAR;
            iqb_pkg::STEP_WIAR:  state_next = iqb_pkg::STEP_WRAI;
            iqb_pkg::STEP_WRAI:  state_next = iqb_pkg::STEP_TIM;
            iqb_pkg::STEP_TIM:   state_next = iqb_pkg::STEP_RR;
            iqb_pkg::STEP_RR:    state_next = iqb_pkg::STEP_II;
            iqb_pkg::STEP_II:    state_next = iqb_pkg::STEP_RI;
            iqb_pkg::STEP_RI:    state_next = iqb_pkg::STEP_UPD;
            iqb_pkg::STEP_UPD:   state_next = iqb_pkg::STEP_FIN;
            iqb_pkg::STEP_FIN:
            begin
                ctrl.finish = out_free;
                if (out_free)
                begin
                    state_next = iqb_pkg::STEP_IDLE;
                end
            end
            default:             state_next = iqb_pkg::STEP_IDLE;
        endcase
    end

endmodule

// ===== tb/iq_balance_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iq_balance_checker
// watches the cfg, in and out channels of the iq balance block, keeps its
// own copy of the correction settings and the image canceller coefficient,
// works out each corrected sample and compares it with the out beats
// ----------------------------------------------------------------------------
module iq_balance_checker #(
    parameter int SW = 16,
    parameter int CW = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [SW-1:0]                 in_re,
    input  logic signed [SW-1:0]                 in_im,
    input  logic                                 block_last,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [SW-1:0]                 out_re,
    input  logic signed [SW-1:0]                 out_im,
    input  logic                                 out_last,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [iqb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [iqb_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam int MU_NUM     = 164;
    localparam int MU_SHIFT   = 2 * SW - CW + 15;

    typedef struct {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 last;
    } iq_beat_t;

    iq_beat_t expected_beats[$];
    iq_beat_t sample_in;
    iq_beat_t oldest;

    logic                  corr_on;
    logic signed [15:0]    gain_q;
    logic signed [15:0]    phase_q;
    logic signed [CW-1:0]  w_re;
    logic signed [CW-1:0]  w_im;
    int                    fail_count;

    function automatic longint clip(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // static fix, image canceller and leaky coefficient update for one sample
    function automatic iq_beat_t balance_sample(input iq_beat_t x);
        longint   a_re;
        longint   a_im;
        longint   t_re;
        longint   t_im;
        longint   sq_re;
        longint   sq_im;
        iq_beat_t y;
        y = x;
        if (corr_on)
        begin
            a_re = clip((longint'(x.re) * longint'(gain_q)) >>> iqb_pkg::GAIN_FRAC, SW);
            a_im = clip(longint'(x.im)
                        + ((longint'(x.re) * longint'(phase_q)) >>> iqb_pkg::PHASE_FRAC),
                        SW);
            // both products summed at full width before the one shift
            t_re = clip(a_re + ((longint'(w_re) * a_re + longint'(w_im) * a_im) >>> (CW - 1)),
                        SW);
            t_im = clip(a_im + ((longint'(w_im) * a_re - longint'(w_re) * a_im) >>> (CW - 1)),
                        SW);
            sq_re = t_re * t_re - t_im * t_im;
            sq_im = 2 * t_re * t_im;
            w_re = CW'(clip(longint'(w_re) - (longint'(w_re) >>> iqb_pkg::LEAK_SHIFT)
                            - ((MU_NUM * sq_re) >>> MU_SHIFT), CW));
            w_im = CW'(clip(longint'(w_im) - (longint'(w_im) >>> iqb_pkg::LEAK_SHIFT)
                            - ((MU_NUM * sq_im) >>> MU_SHIFT), CW));
            y.re = SW'(t_re);
            y.im = SW'(t_im);
        end
        // coefficient restarts with every block, enabled or not
        if (x.last)
        begin
            w_re = '0;
            w_im = '0;
        end
        return y;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_on = 1'b0;
            gain_q  = iqb_pkg::GAIN_RESET;
            phase_q = iqb_pkg::PHASE_RESET;
            w_re    = '0;
            w_im    = '0;
            expected_beats.delete();
            fail_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    iqb_pkg::REG_ENABLE: corr_on = cfg_data[0];
                    iqb_pkg::REG_GAIN:   gain_q  = cfg_data;
                    iqb_pkg::REG_PHASE:  phase_q = cfg_data;
                    default:             ;
                endcase
            end
            // an out beat always belongs to an earlier in beat
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    fail_count++;
                    $error("out beat with no sample waiting: re %0d im %0d last %0d",
                           out_re, out_im, out_last);
                end
                else
                begin
                    oldest = expected_beats.pop_front();
                    check_field("out_re", longint'(oldest.re), longint'(out_re));
                    check_field("out_im", longint'(oldest.im), longint'(out_im));
                    check_field("out_last", longint'(oldest.last), longint'(out_last));
                end
            end
            if (in_valid && in_ready)
            begin
                sample_in.re   = in_re;
                sample_in.im   = in_im;
                sample_in.last = block_last;
                expected_beats.push_back(balance_sample(sample_in));
            end
            mismatches  <= fail_count;
            outstanding <= expected_beats.size();
        end
    end

endmodule

// ===== tb/tb_adaptive_iq_balance.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_iq_balance
// drives samples and register writes into the iq balance block with random
// gaps and output stalls; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb_adaptive_iq_balance;

    localparam int SW              = iqb_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW              = iqb_pkg::COEF_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 50;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 200;

    // index with no register behind it
    localparam logic [iqb_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [SW-1:0]                 in_re;
    logic signed [SW-1:0]                 in_im;
    logic                                 block_last;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [SW-1:0]                 out_re;
    logic signed [SW-1:0]                 out_im;
    logic                                 out_last;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [iqb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index;
    logic [iqb_pkg::CFG_DATA_WIDTH-1:0]   cfg_data;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit bursts_on = 1'b1;

    adaptive_iq_balance #(
        .SAMPLE_WIDTH (SW),
        .COEF_WIDTH   (CW)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_re      (in_re),
        .in_im      (in_im),
        .block_last (block_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_re     (out_re),
        .out_im     (out_im),
        .out_last   (out_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    iq_balance_checker #(
        .SW (SW),
        .CW (CW)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_re       (in_re),
        .in_im       (in_im),
        .block_last  (block_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_re      (out_re),
        .out_im      (out_im),
        .out_last    (out_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: stall bursts while bursts are allowed
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_adaptive_iq_balance: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [SW-1:0] re, input logic [SW-1:0] im,
                               input logic last);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_re      <= re;
        in_im      <= im;
        block_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // hold the sender back until every corrected sample has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [iqb_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [iqb_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SW-1:0] pick_level(input int kind);
        int v;
        case (kind)
            0:
            begin
                return SW'($urandom());
            end
            1, 2:
            begin
                v = $urandom_range(0, 8191) - 4096;
                return v[SW-1:0];
            end
            3:
            begin
                return $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            default:
            begin
                v = $urandom_range(0, 511) - 256;
                return v[SW-1:0];
            end
        endcase
    endfunction

    initial
    begin
        logic [SW-1:0]                       s_re;
        logic [SW-1:0]                       s_im;
        logic                                s_last;
        logic [iqb_pkg::CFG_DATA_WIDTH-1:0]  gain_w;
        logic [iqb_pkg::CFG_DATA_WIDTH-1:0]  phase_w;
        bit                                  en;
        bit                                  last_phase;
        int                                  blk_len;
        int                                  kind;
        int                                  sent;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_re      = '0;
        in_im      = '0;
        block_last = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset the block is disabled: samples pass straight through
        send_sample(S_MIN, S_MAX, 1'b0);
        send_sample(S_MAX, S_MIN, 1'b1);
        wait_idle();
        write_reg(iqb_pkg::REG_ENABLE, 16'd1);

        // unity gain, no phase: full scale corners and a block end
        send_sample(S_MAX, S_MAX, 1'b0);
        send_sample(S_MIN, S_MIN, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b0);
        send_sample('0, '0, 1'b0);
        send_sample(S_MAX, S_MIN, 1'b0);
        send_sample(SW'(1234), SW'(-4321), 1'b1);

        // enable dropped mid-block, coefficient must be held across the gap
        send_sample(SW'(3000), SW'(-2000), 1'b0);
        send_sample(SW'(20000), SW'(5000), 1'b0);
        wait_idle();
        write_reg(iqb_pkg::REG_ENABLE, 16'd0);
        send_sample(SW'(-5000), SW'(7000), 1'b0);
        wait_idle();
        write_reg(iqb_pkg::REG_ENABLE, 16'd1);
        send_sample(SW'(12000), SW'(-9000), 1'b0);
        send_sample(SW'(-15000), SW'(4000), 1'b1);

        // gain and phase at their extremes, driving the saturation paths
        wait_idle();
        write_reg(iqb_pkg::REG_GAIN, 16'h8000);
        write_reg(iqb_pkg::REG_PHASE, 16'h7fff);
        send_sample(S_MIN, S_MAX, 1'b0);
        send_sample(S_MAX, S_MIN, 1'b0);
        send_sample(S_MIN, S_MIN, 1'b1);
        wait_idle();
        write_reg(iqb_pkg::REG_GAIN, 16'h7fff);
        write_reg(iqb_pkg::REG_PHASE, 16'h8000);
        send_sample(S_MAX, S_MAX, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b0);
        send_sample(S_MAX, S_MIN, 1'b1);

        // a write to the spare index must leave every setting alone
        wait_idle();
        write_reg(REG_SPARE, 16'hffff);
        send_sample(SW'(100), SW'(-100), 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            last_phase = (p == RANDOM_PHASES - 1);
            wait_idle();
            bursts_on <= !last_phase;
            en = last_phase || ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 4))
                0:       gain_w = 16'h8000;
                1:       gain_w = 16'h7fff;
                2:       gain_w = iqb_pkg::GAIN_RESET;
                default: gain_w = 16'($urandom_range(10000, 22000));
            endcase
            case ($urandom_range(0, 4))
                0:       phase_w = 16'h8000;
                1:       phase_w = 16'h7fff;
                2:       phase_w = iqb_pkg::PHASE_RESET;
                default: phase_w = 16'($urandom_range(0, 8000) - 4000);
            endcase
            write_reg(iqb_pkg::REG_ENABLE, {15'($urandom()), en});
            write_reg(iqb_pkg::REG_GAIN, gain_w);
            write_reg(iqb_pkg::REG_PHASE, phase_w);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_SPARE, 16'($urandom()));
            end

            sent = 0;
            while (sent < BEATS_PER_PHASE)
            begin
                // mostly whole blocks long enough to let the coefficient settle
                blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(8, 64);
                kind = $urandom_range(0, 5);
                for (int k = 0; k < blk_len; k++)
                begin
                    if (!last_phase && $urandom_range(0, 399) == 0)
                    begin
                        wait_idle();
                    end
                    s_re   = pick_level(kind);
                    s_im   = pick_level(kind);
                    // now and then a block cut short
                    s_last = (k == blk_len - 1) || ($urandom_range(0, 49) == 0);
                    send_sample(s_re, s_im, s_last);
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_adaptive_iq_balance: clean");
        end
        else
        begin
            $display("tb_adaptive_iq_balance: errors");
        end
        $finish;
    end

endmodule

// ===== adaptive_iq_balance.f =====
+incdir+src
src/iqb_pkg.sv
src/iqb_mul.sv
src/iqb_seq.sv
src/adaptive_iq_balance.sv
tb/iq_balance_checker.sv
tb/tb_adaptive_iq_balance.sv
